// File: hdl/mrm_pkg.sv
package mrm_pkg;

  localparam logic [2:0] OP_SETPOINT = 3'd0;
  localparam logic [2:0] OP_RELAY_RD = 3'd1;
  localparam logic [2:0] OP_RELAY_WR = 3'd2;
  localparam logic [2:0] OP_RX_BYTE  = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  localparam logic [1:0] TR_SETPOINT = 2'd0;
  localparam logic [1:0] TR_RELAY_RD = 2'd1;
  localparam logic [1:0] TR_RELAY_WR = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_CRC     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_SKIPPED = 3'd4;
  localparam logic [2:0] ST_BUSY    = 3'd5;

  localparam logic [2:0] REG_INV_ADDR   = 3'd0;
  localparam logic [2:0] REG_RELAY_ADDR = 3'd1;
  localparam logic [2:0] REG_SETPT_REG  = 3'd2;
  localparam logic [2:0] REG_INV_TMO    = 3'd3;
  localparam logic [2:0] REG_RELAY_TMO  = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FN_WRITE_REG   = 8'h06;
  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
  localparam logic [7:0] COIL_BYTES     = 8'h01;
  localparam logic [15:0] COIL_QTY      = 16'h0003;
  localparam logic [7:0] STATE_ALL_OFF  = 8'h0B;
  localparam logic [7:0] STATE_UNKNOWN  = 8'hFF;

  localparam logic [3:0] RX_LEN_SHORT = 4'd5;
  localparam logic [3:0] RX_LEN_LONG  = 4'd8;
  localparam logic [3:0] TX_LEN_SHORT = 4'd6;
  localparam logic [3:0] TX_LEN_LONG  = 4'd8;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] setpoint_watts;
    logic        output_enable;
    logic [7:0]  target_state;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [1:0]  transaction;
    logic [2:0]  status;
    logic [7:0]  state_code;
    logic [2:0]  coil_bits;
    logic [15:0] applied_watts;
    logic [3:0]  fault_bits;
  } out_word_t;

  typedef struct packed {
    logic        is_fin;
    logic        is_long;
    logic [1:0]  trans;
    logic [2:0]  status;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [2:0]  coil;
    logic [7:0]  snap_state;
    logic [2:0]  snap_bits;
    logic [15:0] snap_watts;
    logic [3:0]  snap_err;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic       full;
    logic [2:0] count;
  } q_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: hdl/modbus_rtu_master_transactions.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_data (in_word_t)
// out      output     out_valid/out_ready  out_data (out_word_t)
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// Event words are taken on the in handshake; in_ready drops only while the four-entry
// job queue is full. Unless out_ready stalls it, the back end emits one result word
// per cycle: a request frame gives 8 or 10 words in a row, its CRC built one byte per cycle.
// Reset is synchronous and active low and clears all control state at once.
// A stalled output holds its word while the front end keeps taking events.
module modbus_rtu_master_transactions (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mrm_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import mrm_pkg::*;

  logic    push, pop;
  job_t    push_job, head_job;
  q_stat_t qs;

  assign in_ready = !qs.full;

  mrm_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(in_valid && in_ready), .in_word(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(push), .push_job(push_job)
  );

  mrm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .head_job(head_job), .stat(qs)
  );

  mrm_back u_back (
    .clk(clk), .rst_n(rst_n), .head_job(head_job), .head_valid(qs.valid), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qs.count <= 3'(QDEPTH)) else $error("job queue count beyond depth");
  a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_byte |-> out_data.kind == 1'b0)
    else $error("last byte flag on a finished word");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && qs.count == 3'd0) else $error("not idle after reset");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qs.valid) else $error("pop from empty queue");
`endif

endmodule

// File: hdl/mrm_front.sv
module mrm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  mrm_pkg::in_word_t in_word,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  output logic             push,
  output mrm_pkg::job_t    push_job
);
  import mrm_pkg::*;

  logic [7:0]  inv_addr_r, relay_addr_r;
  logic [15:0] setpt_reg_r, inv_tmo_r, relay_tmo_r;

  logic        busy_r, busy_nxt;
  logic [1:0]  pkind_r, pkind_nxt;
  logic [3:0]  rxcnt_r, rxcnt_nxt;
  logic [15:0] rxcrc_r, rxcrc_nxt;
  logic [7:0]  crclo_r, crclo_nxt;
  logic [7:0]  coil_r, coil_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  pstate_r, pstate_nxt;
  logic [15:0] pwatts_r, pwatts_nxt;
  logic [7:0]  kstate_r, kstate_nxt;
  logic [2:0]  kbits_r, kbits_nxt;
  logic [15:0] awatts_r, awatts_nxt;
  logic [3:0]  err_r, err_nxt;

  logic        fin;
  logic [2:0]  fin_status;
  logic [1:0]  fin_trans;
  logic        frame;
  logic [3:0]  rx_len;
  logic [15:0] watts;
  logic        valid_code;

  always_comb begin
    busy_nxt = busy_r; pkind_nxt = pkind_r; rxcnt_nxt = rxcnt_r; rxcrc_nxt = rxcrc_r;
    crclo_nxt = crclo_r; coil_nxt = coil_r; wait_nxt = wait_r; pstate_nxt = pstate_r;
    pwatts_nxt = pwatts_r; kstate_nxt = kstate_r; kbits_nxt = kbits_r;
    awatts_nxt = awatts_r; err_nxt = err_r;
    fin = 1'b0; fin_status = ST_OK; fin_trans = pkind_r; frame = 1'b0;
    push_job = '0;
    watts = in_word.output_enable ? in_word.setpoint_watts : 16'h0000;
    rx_len = (pkind_r == TR_RELAY_RD) ? RX_LEN_SHORT : RX_LEN_LONG;
    valid_code = (in_word.target_state <= 8'd7) || (in_word.target_state == STATE_ALL_OFF);

    if (accept) begin
      unique case (in_word.op) inside
        OP_SETPOINT, OP_RELAY_RD, OP_RELAY_WR: begin
          if (busy_r) begin
            fin = 1'b1; fin_status = ST_BUSY; fin_trans = in_word.op[1:0];
          end else if (in_word.op == OP_RELAY_WR && in_word.target_state == kstate_r) begin
            fin = 1'b1; fin_status = ST_SKIPPED; fin_trans = TR_RELAY_WR;
          end else if (in_word.op == OP_RELAY_WR && !valid_code) begin
            fin = 1'b1; fin_status = ST_UNKNOWN; fin_trans = TR_RELAY_WR;
          end else begin
            frame = 1'b1;
            busy_nxt = 1'b1; pkind_nxt = in_word.op[1:0]; rxcnt_nxt = '0;
            rxcrc_nxt = CRC_INIT; crclo_nxt = '0; coil_nxt = '0;
            push_job.trans = in_word.op[1:0];
            if (in_word.op == OP_SETPOINT) begin
              pwatts_nxt = watts;
              wait_nxt = inv_tmo_r;
              push_job.addr = inv_addr_r;
              push_job.func = FN_WRITE_REG;
              push_job.word_a = setpt_reg_r;
              push_job.word_b = watts;
            end else begin
              wait_nxt = relay_tmo_r;
              push_job.addr = relay_addr_r;
              push_job.word_b = COIL_QTY;
              if (in_word.op == OP_RELAY_RD) begin
                push_job.func = FN_READ_COILS;
              end else begin
                pstate_nxt = in_word.target_state;
                push_job.func = FN_WRITE_COILS;
                push_job.is_long = 1'b1;
                push_job.coil = (in_word.target_state <= 8'd7) ?
                                in_word.target_state[2:0] : 3'd0;
              end
            end
          end
        end
        OP_RX_BYTE: begin
          if (busy_r) begin
            if (rxcnt_r < rx_len - 4'd2) begin
              rxcrc_nxt = crc16_byte(rxcrc_r, in_word.rx_byte);
              if (pkind_r == TR_RELAY_RD && rxcnt_r == 4'd2) coil_nxt = in_word.rx_byte;
              rxcnt_nxt = rxcnt_r + 4'd1;
            end else if (rxcnt_r == rx_len - 4'd2) begin
              crclo_nxt = in_word.rx_byte;
              rxcnt_nxt = rxcnt_r + 4'd1;
            end else begin
              fin = 1'b1;
              fin_status = ({in_word.rx_byte, crclo_r} == rxcrc_r) ? ST_OK : ST_CRC;
            end
          end
        end
        OP_TICK: begin
          if (busy_r) begin
            if (wait_r <= 16'd1) begin
              wait_nxt = '0; fin = 1'b1; fin_status = ST_TIMEOUT;
            end else begin
              wait_nxt = wait_r - 16'd1;
            end
          end
        end
        default: ;
      endcase

      // A busy, skipped or unknown-code rejection leaves the pending transaction untouched.
      if (fin && fin_status != ST_BUSY && fin_status != ST_SKIPPED &&
          fin_status != ST_UNKNOWN) begin
        busy_nxt = 1'b0; rxcnt_nxt = '0;
        if (fin_status == ST_OK) begin
          if (pkind_r == TR_SETPOINT) begin
            awatts_nxt = pwatts_r; err_nxt = err_r & 4'hC;
          end else if (pkind_r == TR_RELAY_RD) begin
            kbits_nxt = coil_r[2:0]; kstate_nxt = {5'd0, coil_r[2:0]};
            err_nxt = err_r & 4'h3;
          end else begin
            kstate_nxt = pstate_r;
            kbits_nxt = (pstate_r <= 8'd7) ? pstate_r[2:0] : 3'd0;
            err_nxt = err_r & 4'h3;
          end
        end else if (fin_status == ST_TIMEOUT) begin
          err_nxt = err_r | ((pkind_r == TR_SETPOINT) ? 4'h1 : 4'h4);
        end else begin
          err_nxt = err_r | ((pkind_r == TR_SETPOINT) ? 4'h2 : 4'h8);
        end
      end
    end

    push_job.is_fin = fin;
    if (fin) begin
      push_job.trans = fin_trans;
      push_job.status = fin_status;
    end
    push_job.snap_state = kstate_nxt;
    push_job.snap_bits = kbits_nxt;
    push_job.snap_watts = awatts_nxt;
    push_job.snap_err = err_nxt;
    push = fin | frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_addr_r <= 8'd1; relay_addr_r <= 8'd1; setpt_reg_r <= 16'd3000;
      inv_tmo_r <= 16'd500; relay_tmo_r <= 16'd1000;
      busy_r <= 1'b0; pkind_r <= '0; rxcnt_r <= '0; rxcrc_r <= CRC_INIT;
      crclo_r <= '0; coil_r <= '0; wait_r <= '0; pstate_r <= '0; pwatts_r <= '0;
      kstate_r <= STATE_UNKNOWN; kbits_r <= '0; awatts_r <= '0; err_r <= '0;
    end else begin
      busy_r <= busy_nxt; pkind_r <= pkind_nxt; rxcnt_r <= rxcnt_nxt;
      rxcrc_r <= rxcrc_nxt; crclo_r <= crclo_nxt; coil_r <= coil_nxt;
      wait_r <= wait_nxt; pstate_r <= pstate_nxt; pwatts_r <= pwatts_nxt;
      kstate_r <= kstate_nxt; kbits_r <= kbits_nxt; awatts_r <= awatts_nxt;
      err_r <= err_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INV_ADDR:   inv_addr_r <= cfg_wdata[7:0];
          REG_RELAY_ADDR: relay_addr_r <= cfg_wdata[7:0];
          REG_SETPT_REG:  setpt_reg_r <= cfg_wdata;
          REG_INV_TMO:    inv_tmo_r <= cfg_wdata;
          REG_RELAY_TMO:  relay_tmo_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: hdl/mrm_queue.sv
module mrm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrm_pkg::job_t     push_job,
  input  logic              pop,
  output mrm_pkg::job_t     head_job,
  output mrm_pkg::q_stat_t  stat
);
  import mrm_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  job_t          mem_r [QDEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  assign head_job   = mem_r[rd_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == (AW+1)'(QDEPTH));
  assign stat.count = 3'(cnt_r);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// File: hdl/mrm_back.sv
module mrm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mrm_pkg::job_t      head_job,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mrm_pkg::out_word_t out_data
);
  import mrm_pkg::*;

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ov_r;
  out_word_t   od_r, word;
  logic [3:0]  n;
  logic [7:0]  b;
  logic        last, load;

  always_comb begin
    n = head_job.is_long ? TX_LEN_LONG : TX_LEN_SHORT;
    unique case (idx_r)
      4'd0: b = head_job.addr;
      4'd1: b = head_job.func;
      4'd2: b = head_job.word_a[15:8];
      4'd3: b = head_job.word_a[7:0];
      4'd4: b = head_job.word_b[15:8];
      4'd5: b = head_job.word_b[7:0];
      default: b = 8'h00;
    endcase
    // Past the payload, the CRC goes out low byte first.
    if (idx_r == n) b = crc_r[7:0];
    else if (idx_r == n + 4'd1) b = crc_r[15:8];
    else if (idx_r == 4'd6) b = COIL_BYTES;
    else if (idx_r == 4'd7) b = {5'd0, head_job.coil};
    last = (idx_r == n + 4'd1);

    word.kind          = head_job.is_fin;
    word.tx_byte       = head_job.is_fin ? 8'h00 : b;
    word.last_byte     = !head_job.is_fin && last;
    word.transaction   = head_job.trans;
    word.status        = head_job.is_fin ? head_job.status : ST_OK;
    word.state_code    = head_job.snap_state;
    word.coil_bits     = head_job.snap_bits;
    word.applied_watts = head_job.snap_watts;
    word.fault_bits    = head_job.snap_err;

    load = head_valid && (!ov_r || out_ready);
    pop = load && (head_job.is_fin || last);
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (load && !head_job.is_fin) begin
      if (last) begin
        idx_nxt = '0; crc_nxt = CRC_INIT;
      end else begin
        idx_nxt = idx_r + 4'd1;
        if (idx_r < n) crc_nxt = crc16_byte(crc_r, b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; crc_r <= CRC_INIT; ov_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt; crc_r <= crc_nxt;
      if (load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) od_r <= word;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
